### hdl/bounding_sphere_union_defines.svh
// Assertion macros shared by the bounding sphere union RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef BOUNDING_SPHERE_UNION_DEFINES_SVH
`define BOUNDING_SPHERE_UNION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSU_CHECK_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSU_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bsu_pkg.sv
// Shared constants of the bounding sphere union block.
// No dependencies; imported by the interfaces, bsu_div and bounding_sphere_union.
package bsu_pkg;

  localparam int UNIT_SHIFT = 30;
  localparam int QUOT_W = UNIT_SHIFT + 1;
  localparam int RAD_W = 31;
  localparam logic [RAD_W-1:0] RAD_MAX = '1;
  localparam logic [QUOT_W-1:0] UNIT_ONE = QUOT_W'(1) << UNIT_SHIFT;

endpackage

### hdl/bsu_pair_if.sv
// Input channel: one word holds two spheres, center and radius each.
// Depends on bsu_pkg for the radius width.
interface bsu_pair_if import bsu_pkg::*; #(parameter int COORD_WIDTH = 32) ();

  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] a_center_x;
  logic signed [COORD_WIDTH-1:0] a_center_y;
  logic signed [COORD_WIDTH-1:0] a_center_z;
  logic [RAD_W-1:0] a_radius;
  logic signed [COORD_WIDTH-1:0] b_center_x;
  logic signed [COORD_WIDTH-1:0] b_center_y;
  logic signed [COORD_WIDTH-1:0] b_center_z;
  logic [RAD_W-1:0] b_radius;

  modport source (output valid, a_center_x, a_center_y, a_center_z, a_radius,
                  b_center_x, b_center_y, b_center_z, b_radius, input ready);
  modport sink (input valid, a_center_x, a_center_y, a_center_z, a_radius,
                b_center_x, b_center_y, b_center_z, b_radius, output ready);

endinterface

### hdl/bsu_sphere_if.sv
// Output channel: one word holds the enclosing sphere.
// Depends on bsu_pkg for the radius width.
interface bsu_sphere_if import bsu_pkg::*; #(parameter int COORD_WIDTH = 32) ();

  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] u_center_x;
  logic signed [COORD_WIDTH-1:0] u_center_y;
  logic signed [COORD_WIDTH-1:0] u_center_z;
  logic [RAD_W-1:0] u_radius;

  modport source (output valid, u_center_x, u_center_y, u_center_z, u_radius,
                  input ready);
  modport sink (input valid, u_center_x, u_center_y, u_center_z, u_radius,
                output ready);

endinterface

### hdl/bsu_sqsum.sv
// Three-stage sum of three squares, each square split into half-width products.
// Depends on nothing beyond its parameters.
module bsu_sqsum #(
  parameter int MW = 33,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MW-1:0]     mag [3],
  input  logic [SW-1:0]     side_in,
  output logic              out_valid,
  output logic [2*MW+1:0]   sum,
  output logic [SW-1:0]     side_out
);

  localparam int K = (MW + 1) / 2;
  localparam int H = MW - K;

  logic [2*K-1:0]  ll [3];
  logic [K+H-1:0]  lh [3];
  logic [2*H-1:0]  hh [3];
  logic [2*MW-1:0] sq [3];
  logic [SW-1:0]   side_a;
  logic [SW-1:0]   side_b;
  logic            va;
  logic            vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  // Partial products, then the squares, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ll[i] <= (2*K)'(mag[i][K-1:0]) * (2*K)'(mag[i][K-1:0]);
        lh[i] <= (K+H)'(mag[i][K-1:0]) * (K+H)'(mag[i][MW-1:K]);
        hh[i] <= (2*H)'(mag[i][MW-1:K]) * (2*H)'(mag[i][MW-1:K]);
        sq[i] <= ((2*MW)'(hh[i]) << (2*K)) + ((2*MW)'(lh[i]) << (K+1))
                 + (2*MW)'(ll[i]);
      end
      sum <= (2*MW+2)'(sq[0]) + (2*MW+2)'(sq[1]) + (2*MW+2)'(sq[2]);
      side_a <= side_in;
      side_b <= side_a;
      side_out <= side_b;
    end
  end

endmodule

### hdl/bsu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on nothing beyond its parameters.
module bsu_sqrt #(
  parameter int IW = 68,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IW-1:0]     radicand,
  input  logic [SW-1:0]     side_in,
  output logic              out_valid,
  output logic [IW/2-1:0]   root,
  output logic [SW-1:0]     side_out
);

  localparam int N = IW / 2;
  localparam int RW = N + 3;

  logic [N-1:0]  root_q [N];
  logic [RW-1:0] rem_q  [N];
  logic [IW-1:0] x_q    [N];
  logic [SW-1:0] side_q [N];
  logic          v_q    [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int I = N - 1 - k;
    logic [N-1:0]  root_in;
    logic [RW-1:0] rem_in;
    logic [IW-1:0] x_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in = '0;
      assign x_in = radicand;
      assign s_in = side_in;
      assign v_in = in_valid;
    end else begin : g_next
      assign root_in = root_q[k-1];
      assign rem_in = rem_q[k-1];
      assign x_in = x_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = v_q[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], x_in[2*I+1 -: 2]};
    assign trial = RW'({root_in, 2'b01});
    assign ge = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[N-2:0], ge};
        x_q[k] <= x_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign out_valid = v_q[N-1];
  assign root = root_q[N-1];
  assign side_out = side_q[N-1];

endmodule

### hdl/bsu_div.sv
// Pipelined restoring divider, three lanes over one shared divisor,
// one quotient bit per stage. Depends on bsu_pkg for the quotient width.
module bsu_div import bsu_pkg::*; #(
  parameter int DW = 33,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     num [3],
  input  logic [DW-1:0]     divisor,
  input  logic [SW-1:0]     side_in,
  output logic              out_valid,
  output logic [QUOT_W-1:0] quot [3],
  output logic [SW-1:0]     side_out
);

  // The numerator is num scaled up by UNIT_SHIFT bits; num never exceeds the
  // divisor, so the quotient fits QUOT_W bits and the first partial
  // remainder is num with its last bit held back.
  logic [DW-1:0]     rem_q  [QUOT_W][3];
  logic [QUOT_W-1:0] q_q    [QUOT_W][3];
  logic [DW-1:0]     d_q    [QUOT_W];
  logic [SW-1:0]     side_q [QUOT_W];
  logic              v_q    [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [DW-1:0]     rem_in [3];
    logic [QUOT_W-1:0] q_in   [3];
    logic              nb     [3];
    logic [DW:0]       rs     [3];
    logic              ge     [3];
    logic [DW-1:0]     d_in;
    logic [SW-1:0]     s_in;
    logic              v_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          rem_in[j] = {1'b0, num[j][DW-1:1]};
          q_in[j] = '0;
          nb[j] = num[j][0];
        end
      end
      assign d_in = divisor;
      assign s_in = side_in;
      assign v_in = in_valid;
    end else begin : g_next
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          rem_in[j] = rem_q[k-1][j];
          q_in[j] = q_q[k-1][j];
          nb[j] = 1'b0;
        end
      end
      assign d_in = d_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = v_q[k-1];
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        rs[j] = {rem_in[j], nb[j]};
        ge[j] = rs[j] >= {1'b0, d_in};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          rem_q[k][j] <= ge[j] ? DW'(rs[j] - {1'b0, d_in}) : rs[j][DW-1:0];
          q_q[k][j] <= {q_in[j][QUOT_W-2:0], ge[j]};
        end
        d_q[k] <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign out_valid = v_q[QUOT_W-1];
  assign side_out = side_q[QUOT_W-1];
  always_comb begin
    for (int j = 0; j < 3; j++) quot[j] = q_q[QUOT_W-1][j];
  end

endmodule

### hdl/bounding_sphere_union.sv
// Depth is set by the two bit-per-stage square roots and the 31-stage
// unit-vector divider. Throughput: one word per cycle while the output skid
// is empty; a parked word that the sink refuses halts the whole pipe.
// Reset (synchronous, active high) empties every stage and the output skid.
`include "bounding_sphere_union_defines.svh"

module bounding_sphere_union import bsu_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input logic          clk,
  input logic          rst,
  bsu_pair_if.sink     pair,
  bsu_sphere_if.source merged
);

  localparam int W = COORD_WIDTH;
  localparam int MW1 = W + 1;                    // |center difference|
  localparam int SQ1 = 2 * MW1 + 2;              // its squared length
  localparam int EW = ((W > 32) ? W : 32) + 1;   // extreme point coordinate
  localparam int MW2 = EW + 1;                   // |eA - eB|
  localparam int SQ2 = 2 * MW2 + 2;
  localparam int LW = SQ2 / 2;                   // width of |eA - eB|
  localparam int CW = (W + 1 > RAD_W) ? W + 1 : RAD_W;
  localparam int PW = QUOT_W + RAD_W;

  typedef logic [RAD_W-1:0] rad_t;

  typedef struct packed {
    logic [2:0][W-1:0] c;
    rad_t              r;
  } sphere_t;

  // An empty input sphere makes the result the other sphere; that result
  // rides along the whole pipe and replaces the computed one at the end.
  typedef struct packed {
    logic    hit;
    sphere_t s;
  } byp_t;

  typedef struct packed {
    logic [2:0]          neg;
    logic [2:0][MW1-1:0] mag;
    logic [2:0][W-1:0]   ca;
    logic [2:0][W-1:0]   cb;
    rad_t                ra;
    rad_t                rb;
    byp_t                byp;
  } side1_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][W-1:0] ca;
    logic [2:0][W-1:0] cb;
    rad_t              ma;
    rad_t              mb;
    logic              dz;
    byp_t              byp;
  } side2_t;

  typedef struct packed {
    logic [2:0][EW-1:0] mid;
    byp_t               byp;
  } side3_t;

  // Extent of one sphere along the axis: max(r_self, r_other - d).
  function automatic rad_t reach(rad_t r_self, rad_t r_other, logic [W:0] d);
    rad_t t;
    t = r_self;
    if (CW'(d) < CW'(r_other)) begin
      t = RAD_W'(CW'(r_other) - CW'(d));
      if (t < r_self) t = r_self;
    end
    return t;
  endfunction

  // The whole pipe moves together; it halts only while the skid register
  // holds a word that the sink has not taken.
  logic en;
  logic skid_full;
  sphere_t skid;

  assign en = !skid_full;
  assign pair.ready = en;

  // Stage 0: input register.
  logic v0;
  logic [2:0][W-1:0] ca0, cb0;
  rad_t ra0, rb0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca0 <= {pair.a_center_z, pair.a_center_y, pair.a_center_x};
      cb0 <= {pair.b_center_z, pair.b_center_y, pair.b_center_x};
      ra0 <= pair.a_radius;
      rb0 <= pair.b_radius;
    end
  end

  // Stage 1: center difference, its magnitude and sign, and the empty-sphere
  // pass-through.
  logic v1;
  side1_t s1, s1_next;
  logic [MW1-1:0] mag1 [3];

  always_comb begin
    logic signed [W:0] df;
    s1_next.ca = ca0;
    s1_next.cb = cb0;
    s1_next.ra = ra0;
    s1_next.rb = rb0;
    for (int i = 0; i < 3; i++) begin
      df = (W+1)'($signed(ca0[i])) - (W+1)'($signed(cb0[i]));
      s1_next.neg[i] = df[W];
      s1_next.mag[i] = df[W] ? MW1'(-df) : MW1'(df);
    end
    s1_next.byp.hit = (ra0 == '0) || (rb0 == '0);
    if (ra0 == '0) begin
      s1_next.byp.s.c = cb0;
      s1_next.byp.s.r = rb0;
    end else begin
      s1_next.byp.s.c = ca0;
      s1_next.byp.s.r = ra0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) s1 <= s1_next;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) mag1[i] = s1.mag[i];
  end

  // Squared length of the difference, then its floor square root d.
  logic vq1, vr1;
  logic [SQ1-1:0] sum1;
  logic [SQ1/2-1:0] root1;
  side1_t sq1_side, rt1_side;

  bsu_sqsum #(.MW(MW1), .SW($bits(side1_t))) u_sqsum_d (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .mag(mag1), .side_in(s1),
    .out_valid(vq1), .sum(sum1), .side_out(sq1_side)
  );

  bsu_sqrt #(.IW(SQ1), .SW($bits(side1_t))) u_sqrt_d (
    .clk(clk), .rst(rst), .en(en), .in_valid(vq1), .radicand(sum1),
    .side_in(sq1_side), .out_valid(vr1), .root(root1), .side_out(rt1_side)
  );

  // Stage 2: the two extents and the zero-distance flag.
  logic v2;
  side2_t s2;
  logic [W:0] d2;
  logic [W:0] num2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= vr1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2 <= root1[W:0];
      for (int i = 0; i < 3; i++) num2[i] <= rt1_side.mag[i];
      s2.neg <= rt1_side.neg;
      s2.ca <= rt1_side.ca;
      s2.cb <= rt1_side.cb;
      s2.ma <= reach(rt1_side.ra, rt1_side.rb, root1[W:0]);
      s2.mb <= reach(rt1_side.rb, rt1_side.ra, root1[W:0]);
      s2.dz <= root1 == '0;
      s2.byp <= rt1_side.byp;
    end
  end

  // Unit direction, |D_i| / d in unsigned Q1.30.
  logic vdv;
  logic [QUOT_W-1:0] quot [3];
  side2_t dv_side;

  bsu_div #(.DW(W + 1), .SW($bits(side2_t))) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .num(num2), .divisor(d2),
    .side_in(s2), .out_valid(vdv), .quot(quot), .side_out(dv_side)
  );

  // Stage 3: offsets along the direction. Coincident centers take the X axis.
  logic v3;
  logic [PW-1:0] pa [3];
  logic [PW-1:0] pb [3];
  logic [QUOT_W-1:0] unit [3];
  side2_t s3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_side.dz) begin
        unit[i] = (i == 0) ? UNIT_ONE : '0;
      end else begin
        unit[i] = quot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vdv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= PW'(unit[i]) * PW'(dv_side.ma);
        pb[i] <= PW'(unit[i]) * PW'(dv_side.mb);
      end
      s3 <= dv_side;
    end
  end

  // Stage 4: extreme points eA = cA + offset and eB = cB - offset.
  logic v4;
  logic signed [EW-1:0] ea4 [3];
  logic signed [EW-1:0] eb4 [3];
  logic signed [EW-1:0] ea4_next [3];
  logic signed [EW-1:0] eb4_next [3];
  byp_t byp4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [EW-1:0] oa;
      logic signed [EW-1:0] ob;
      oa = EW'(pa[i][UNIT_SHIFT +: RAD_W]);
      ob = EW'(pb[i][UNIT_SHIFT +: RAD_W]);
      if (s3.neg[i]) begin
        oa = -oa;
        ob = -ob;
      end
      ea4_next[i] = EW'($signed(s3.ca[i])) + oa;
      eb4_next[i] = EW'($signed(s3.cb[i])) - ob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea4 <= ea4_next;
      eb4 <= eb4_next;
      byp4 <= s3.byp;
    end
  end

  // Stage 5: midpoint (rounded toward minus infinity) and |eA - eB|.
  logic v5;
  side3_t s5;
  logic [MW2-1:0] m5 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [EW:0] sm;
    logic signed [EW:0] df;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sm = (EW+1)'(ea4[i]) + (EW+1)'(eb4[i]);
        df = (EW+1)'(ea4[i]) - (EW+1)'(eb4[i]);
        s5.mid[i] <= sm[EW:1];
        m5[i] <= df[EW] ? MW2'(-df) : MW2'(df);
      end
      s5.byp <= byp4;
    end
  end

  // Length of eA - eB.
  logic vq2, vr2;
  logic [SQ2-1:0] sum2;
  logic [LW-1:0] root2;
  side3_t sq2_side, rt2_side;

  bsu_sqsum #(.MW(MW2), .SW($bits(side3_t))) u_sqsum_len (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5), .mag(m5), .side_in(s5),
    .out_valid(vq2), .sum(sum2), .side_out(sq2_side)
  );

  bsu_sqrt #(.IW(SQ2), .SW($bits(side3_t))) u_sqrt_len (
    .clk(clk), .rst(rst), .en(en), .in_valid(vq2), .radicand(sum2),
    .side_in(sq2_side), .out_valid(vr2), .root(root2), .side_out(rt2_side)
  );

  // Stage 6: halve the length, saturate, and choose the pass-through result.
  logic v6;
  sphere_t last_q, last_next;

  always_comb begin
    logic [LW-2:0] half;
    logic [EW-1:0] mid;
    half = root2[LW-1:1];
    last_next.r = (half[LW-2:RAD_W] != '0) ? RAD_MAX : half[RAD_W-1:0];
    for (int i = 0; i < 3; i++) begin
      mid = rt2_side.mid[i];
      if ((mid[EW-1:W-1] == '0) || (mid[EW-1:W-1] == '1)) begin
        last_next.c[i] = mid[W-1:0];
      end else begin
        last_next.c[i] = {mid[EW-1], {(W-1){!mid[EW-1]}}};
      end
    end
    if (rt2_side.byp.hit) last_next = rt2_side.byp.s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vr2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) last_q <= last_next;
  end

  // Output skid: a word the sink refuses is parked here so the pipe can
  // take one more step; the pipe then waits until the parked word leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (!skid_full) begin
      skid_full <= v6 && !merged.ready;
    end else if (merged.ready) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) skid <= last_q;
  end

  sphere_t shown;
  assign shown = skid_full ? skid : last_q;
  assign merged.valid = skid_full || v6;
  assign merged.u_center_x = shown.c[0];
  assign merged.u_center_y = shown.c[1];
  assign merged.u_center_z = shown.c[2];
  assign merged.u_radius = shown.r;

  `BSU_CHECK_NEXT(a_skid_hold, clk, rst, skid_full && !merged.ready, skid_full && $stable(skid), "parked word changed while refused")
  `BSU_CHECK_NEXT(a_skid_load, clk, rst, !skid_full && v6 && !merged.ready, skid_full, "refused word was not parked")
  `BSU_CHECK_NEXT(a_pipe_frozen, clk, rst, skid_full, $stable(v6) && $stable(last_q), "pipe moved during a stall")
  `BSU_CHECK_NEXT(a_accept_enters, clk, rst, pair.valid && pair.ready, v0, "accepted word did not enter stage zero")

endmodule
